/* rtl/weighted_union_find_halving_top_macros.svh */
// Assertion macros for the union-find engine.
// Used by weighted_union_find_halving_top; expects clk and rst_n in scope.
`ifndef WEIGHTED_UNION_FIND_HALVING_TOP_MACROS_SVH
`define WEIGHTED_UNION_FIND_HALVING_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define WUF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WUF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wuf_pkg.sv */
// Shared types for the union-find engine: sequencer states and ALU codes.
// No dependencies.
package wuf_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_FIND_RD,
        ST_FIND_P,
        ST_FIND_G,
        ST_CMP_ROOT,
        ST_SZ_B,
        ST_LINK,
        ST_SUM
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

/* rtl/weighted_union_find_halving_top.sv */
// Top level of the weighted union-find engine with path halving.
// Depends on wuf_pkg, wuf_ram, wuf_alu and the assertion macro header.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------------
//  input   | first_node, second_node            | taken when start && !busy
//  result  | already_joined, final_root         | one-cycle done strobe, no stall
//
// After reset a clearing pass over all NODE_COUNT entries loads the parent and
// size stores; busy stays high meanwhile. An item then reduces indices not below
// NODE_COUNT by repeated subtraction (none for NODE_COUNT >= 256), finds both
// roots with path halving and, when the roots differ, merges the smaller set
// under the larger. The single read port of the parent RAM makes each hop a
// parent read followed by a grandparent read. done follows the last step and
// the block is ready again in that same cycle.
`include "weighted_union_find_halving_top_macros.svh"

module weighted_union_find_halving_top #(
    parameter int NODE_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] first_node,
    input  logic [7:0] second_node,
    output logic       done,
    output logic       already_joined,
    output logic [7:0] final_root
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int SIZE_W = $clog2(NODE_COUNT + 1);
    localparam int OPW    = (SIZE_W > 9) ? SIZE_W : 9;

    wuf_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [7:0]        a_reg, a_next;
    logic [7:0]        b_reg, b_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    logic [IDX_W-1:0]  rb_reg, rb_next;
    logic              phase_reg, phase_next;
    logic [SIZE_W-1:0] sa_reg, sa_next;
    logic [SIZE_W-1:0] sb_reg, sb_next;
    logic              lt_reg, lt_next;
    logic              done_reg, done_next;
    logic              joined_reg, joined_next;
    logic [7:0]        root_reg, root_next;

    logic              par_we;
    logic [IDX_W-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
    logic              sz_we;
    logic [IDX_W-1:0]  sz_waddr, sz_raddr;
    logic [SIZE_W-1:0] sz_wdata, sz_rdata;

    wuf_pkg::alu_op_t  alu_op;
    logic [OPW-1:0]    alu_a, alu_b, alu_res;
    logic              alu_eq, alu_lt;

    logic [IDX_W-1:0]  small_root, big_root;

    wuf_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    wuf_ram #(.WIDTH(SIZE_W), .DEPTH(NODE_COUNT)) u_size (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    wuf_alu #(.W(OPW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .eq  (alu_eq),
        .lt  (alu_lt)
    );

    assign small_root = lt_reg ? ra_reg : rb_reg;
    assign big_root   = lt_reg ? rb_reg : ra_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wuf_pkg::ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        phase_reg  <= phase_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        lt_reg     <= lt_next;
        joined_reg <= joined_next;
        root_reg   <= root_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wuf_pkg::ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(NODE_COUNT - 1))
                begin
                    state_next = wuf_pkg::ST_IDLE;
                end
            end
            wuf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = wuf_pkg::ST_RED_A;
                end
            end
            wuf_pkg::ST_RED_A:
            begin
                if (alu_lt)
                begin
                    state_next = wuf_pkg::ST_RED_B;
                end
            end
            wuf_pkg::ST_RED_B:
            begin
                if (alu_lt)
                begin
                    state_next = wuf_pkg::ST_FIND_RD;
                end
            end
            wuf_pkg::ST_FIND_RD: state_next = wuf_pkg::ST_FIND_P;
            wuf_pkg::ST_FIND_P:
            begin
                if (!alu_eq)
                begin
                    state_next = wuf_pkg::ST_FIND_G;
                end
                else if (!phase_reg)
                begin
                    state_next = wuf_pkg::ST_FIND_RD;
                end
                else
                begin
                    state_next = wuf_pkg::ST_CMP_ROOT;
                end
            end
            wuf_pkg::ST_FIND_G:  state_next = wuf_pkg::ST_FIND_P;
            wuf_pkg::ST_CMP_ROOT:
            begin
                state_next = alu_eq ? wuf_pkg::ST_IDLE : wuf_pkg::ST_SZ_B;
            end
            wuf_pkg::ST_SZ_B:    state_next = wuf_pkg::ST_LINK;
            wuf_pkg::ST_LINK:    state_next = wuf_pkg::ST_SUM;
            wuf_pkg::ST_SUM:     state_next = wuf_pkg::ST_IDLE;
            default:             state_next = wuf_pkg::ST_CLEAR;
        endcase
    end

    // memory controls and shared unit operands
    always_comb
    begin
        par_we    = 1'b0;
        par_waddr = cur_reg;
        par_wdata = par_rdata;
        par_raddr = cur_reg;
        sz_we     = 1'b0;
        sz_waddr  = clr_reg;
        sz_wdata  = SIZE_W'(1);
        sz_raddr  = ra_reg;
        alu_op    = wuf_pkg::ALU_SUB;
        alu_a     = OPW'(a_reg);
        alu_b     = OPW'(NODE_COUNT);
        case (state_reg)
            wuf_pkg::ST_CLEAR:
            begin
                par_we    = 1'b1;
                par_waddr = clr_reg;
                par_wdata = clr_reg;
                sz_we     = 1'b1;
            end
            wuf_pkg::ST_RED_A:
            begin
                alu_a = OPW'(a_reg);
            end
            wuf_pkg::ST_RED_B:
            begin
                alu_a = OPW'(b_reg);
            end
            wuf_pkg::ST_FIND_P:
            begin
                // compare parent against node; fetch grandparent
                alu_a     = OPW'(par_rdata);
                alu_b     = OPW'(cur_reg);
                par_raddr = par_rdata;
            end
            wuf_pkg::ST_FIND_G:
            begin
                // halve: point node at grandparent, then advance to it
                par_we    = 1'b1;
                par_waddr = cur_reg;
                par_wdata = par_rdata;
                par_raddr = par_rdata;
            end
            wuf_pkg::ST_CMP_ROOT:
            begin
                alu_a    = OPW'(ra_reg);
                alu_b    = OPW'(rb_reg);
                sz_raddr = ra_reg;
            end
            wuf_pkg::ST_SZ_B:
            begin
                sz_raddr = rb_reg;
            end
            wuf_pkg::ST_LINK:
            begin
                alu_a = OPW'(sa_reg);
                alu_b = OPW'(sz_rdata);
            end
            wuf_pkg::ST_SUM:
            begin
                alu_op    = wuf_pkg::ALU_ADD;
                alu_a     = OPW'(sa_reg);
                alu_b     = OPW'(sb_reg);
                par_we    = 1'b1;
                par_waddr = small_root;
                par_wdata = big_root;
                sz_we     = 1'b1;
                sz_waddr  = big_root;
                sz_wdata  = SIZE_W'(alu_res);
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_next    = clr_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        phase_next  = phase_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        lt_next     = lt_reg;
        done_next   = 1'b0;
        joined_next = joined_reg;
        root_next   = root_reg;
        case (state_reg)
            wuf_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
            end
            wuf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    a_next = first_node;
                    b_next = second_node;
                end
            end
            wuf_pkg::ST_RED_A:
            begin
                if (!alu_lt)
                begin
                    a_next = alu_res[7:0];
                end
            end
            wuf_pkg::ST_RED_B:
            begin
                if (!alu_lt)
                begin
                    b_next = alu_res[7:0];
                end
                else
                begin
                    cur_next   = IDX_W'(a_reg);
                    phase_next = 1'b0;
                end
            end
            wuf_pkg::ST_FIND_P:
            begin
                if (alu_eq && !phase_reg)
                begin
                    ra_next    = cur_reg;
                    cur_next   = IDX_W'(b_reg);
                    phase_next = 1'b1;
                end
                else if (alu_eq)
                begin
                    rb_next = cur_reg;
                end
            end
            wuf_pkg::ST_FIND_G:
            begin
                cur_next = par_rdata;
            end
            wuf_pkg::ST_CMP_ROOT:
            begin
                if (alu_eq)
                begin
                    done_next   = 1'b1;
                    joined_next = 1'b1;
                    root_next   = 8'(ra_reg);
                end
            end
            wuf_pkg::ST_SZ_B:
            begin
                sa_next = sz_rdata;
            end
            wuf_pkg::ST_LINK:
            begin
                sb_next = sz_rdata;
                lt_next = alu_lt;
            end
            wuf_pkg::ST_SUM:
            begin
                done_next   = 1'b1;
                joined_next = 1'b0;
                root_next   = 8'(big_root);
            end
            default:
            begin
            end
        endcase
    end

    assign busy           = (state_reg != wuf_pkg::ST_IDLE);
    assign done           = done_reg;
    assign already_joined = joined_reg;
    assign final_root     = root_reg;

    `WUF_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
    `WUF_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
    `WUF_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `WUF_ASSERT_IMP(a_halve_addr, state_reg == wuf_pkg::ST_FIND_G, par_rdata != cur_reg,
        "halving step writes the node it reads")

endmodule

/* rtl/wuf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wuf_alu.sv */
// Shared add/subtract and compare unit used by the sequencer.
// Depends on wuf_pkg.
module wuf_alu #(
    parameter int W = 9
) (
    input  wuf_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     res,
    output logic             eq,
    output logic             lt
);

    always_comb
    begin
        case (op)
            wuf_pkg::ALU_ADD: res = a + b;
            wuf_pkg::ALU_SUB: res = a - b;
            default:          res = a + b;
        endcase
    end

    assign eq = (a == b);
    assign lt = (a < b);

endmodule

/* verif/weighted_union_find_halving_checker.sv */
// Checker for the union-find engine: tracks every accepted node pair,
// predicts connected flag and root with its own parent and size tables.
// Standalone; connects only to the ports of weighted_union_find_halving_top.
module weighted_union_find_halving_checker #(
    parameter int NODE_COUNT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [7:0] first_node,
    input  logic [7:0] second_node,
    input  logic       done,
    input  logic       already_joined,
    input  logic [7:0] final_root,
    output int         mismatch_count,
    output int         outcomes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       joined;
        logic [7:0] root;
    } union_outcome_t;

    logic [7:0]     parent_of [NODE_COUNT];
    logic [8:0]     set_size [NODE_COUNT];
    union_outcome_t predicted_outcomes [$];

    // Walk to the root, pointing each visited node at its grandparent.
    function automatic logic [7:0] find_root_halving(input logic [7:0] node);
        logic [7:0] cur;
        cur = node;
        while (parent_of[cur] != cur) begin
            parent_of[cur] = parent_of[parent_of[cur]];
            cur = parent_of[cur];
        end
        return cur;
    endfunction

    function automatic union_outcome_t predict_union(input logic [7:0] node_a,
                                                     input logic [7:0] node_b);
        logic [7:0]     root_a;
        logic [7:0]     root_b;
        union_outcome_t outcome;
        root_a = find_root_halving(8'(node_a % NODE_COUNT));
        root_b = find_root_halving(8'(node_b % NODE_COUNT));
        if (root_a == root_b) begin
            outcome.joined = 1'b1;
            outcome.root   = root_a;
        end else if (set_size[root_a] < set_size[root_b]) begin
            parent_of[root_a] = root_b;
            set_size[root_b]  = set_size[root_b] + set_size[root_a];
            outcome.joined    = 1'b0;
            outcome.root      = root_b;
        end else begin
            // ties: second root goes under the first
            parent_of[root_b] = root_a;
            set_size[root_a]  = set_size[root_a] + set_size[root_b];
            outcome.joined    = 1'b0;
            outcome.root      = root_a;
        end
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        union_outcome_t wanted;
        if (!rst_n)
        begin
            for (int k = 0; k < NODE_COUNT; k++)
            begin
                parent_of[k] = 8'(k);
                set_size[k]  = 9'd1;
            end
            predicted_outcomes.delete();
            mismatch_count   <= 0;
            outcomes_pending <= 0;
        end
        else
        begin
            // retire the finished item before taking a new one in the same cycle
            if (done)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result joined=%0b root=%0d",
                             $time, already_joined, final_root);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    wanted = predicted_outcomes.pop_front();
                    if (already_joined !== wanted.joined || final_root !== wanted.root)
                    begin
                        $display("%0t: expected joined=%0b root=%0d, actual joined=%0b root=%0d",
                                 $time, wanted.joined, wanted.root,
                                 already_joined, final_root);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start && !busy)
                predicted_outcomes.push_back(predict_union(first_node, second_node));
            outcomes_pending <= predicted_outcomes.size();
        end
    end
endmodule

/* verif/weighted_union_find_halving_top_test.sv */
// Testbench top for the union-find engine: clock, reset, node-pair stimulus
// and verdict. Depends on weighted_union_find_halving_top and the checker.
module weighted_union_find_halving_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_COUNT   = 256;
    localparam int RANDOM_ITEMS = 1750;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 600000;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       start       = 1'b0;
    logic [7:0] first_node  = 8'd0;
    logic [7:0] second_node = 8'd0;
    logic       busy;
    logic       done;
    logic       already_joined;
    logic [7:0] final_root;
    int         mismatch_count;
    int         outcomes_pending;

    weighted_union_find_halving_top #(.NODE_COUNT(NODE_COUNT)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_node    (first_node),
        .second_node   (second_node),
        .done          (done),
        .already_joined(already_joined),
        .final_root    (final_root)
    );

    weighted_union_find_halving_checker #(.NODE_COUNT(NODE_COUNT)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .first_node      (first_node),
        .second_node     (second_node),
        .done            (done),
        .already_joined  (already_joined),
        .final_root      (final_root),
        .mismatch_count  (mismatch_count),
        .outcomes_pending(outcomes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Called in the step of a rising edge; returns in the step of the acceptance.
    task automatic send_pair(input logic [7:0] node_a, input logic [7:0] node_b,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        first_node  <= node_a;
        second_node <= node_b;
        do @(posedge clk); while (busy);
    endtask

    // Hold off until every predicted result has come back, then let the block settle.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (outcomes_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int         idle_pct;
        int         pick;
        logic [7:0] node_a;
        logic [7:0] node_b;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: same node, extremes, ties, small under large, halving on deep trees
        send_pair(8'd0,   8'd0,   0);
        send_pair(8'd255, 8'd255, 0);
        send_pair(8'd0,   8'd255, 0);
        send_pair(8'd1,   8'd2,   0);
        send_pair(8'd1,   8'd0,   0);
        send_pair(8'd3,   8'd0,   0);
        send_pair(8'd255, 8'd3,   0);
        send_pair(8'd128, 8'd129, 0);
        send_pair(8'd130, 8'd131, 0);
        send_pair(8'd132, 8'd133, 0);
        send_pair(8'd134, 8'd135, 0);
        send_pair(8'd128, 8'd130, 0);
        send_pair(8'd132, 8'd134, 0);
        send_pair(8'd129, 8'd135, 0);
        send_pair(8'd135, 8'd131, 0);
        send_pair(8'd85,  8'd170, 0);
        send_pair(8'd170, 8'd255, 0);
        send_pair(8'd133, 8'd1,   0);
        send_pair(8'd254, 8'd127, 0);
        send_pair(8'd2,   8'd131, 0);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                pick   = $urandom_range(9);
                node_a = 8'($urandom_range(255));
                if (pick < 4)
                    node_b = 8'($urandom_range(255));
                else if (pick < 8)
                    node_b = node_a + 8'($urandom_range(1, 7)); // grow neighborhoods
                else if (pick < 9)
                    node_b = node_a;
                else
                    node_b = ~node_a;
                // stretches with no idling even in the idle phases
                send_pair(node_a, node_b, (n % 100 < 15) ? 0 : idle_pct);
            end
            drain_results();
        end

        if (mismatch_count == 0 && outcomes_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
